@@ rtl/calendar_date_adder_core_assert.svh @@
// ----------------------------------------------------------------------------
// calendar date adder assertion macros
// concurrent checks on the core clock, off during reset
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DATE_ADDER_CORE_ASSERT_SVH
`define CALENDAR_DATE_ADDER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define CDADD_ASSERT_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("calendar date adder check failed");
`define CDADD_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("calendar date adder sequence check failed");
`else
`define CDADD_ASSERT_ALWAYS(lbl, cond)
`define CDADD_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

@@ rtl/cdadd_pkg.sv @@
// ----------------------------------------------------------------------------
// cdadd_pkg
// shared widths, operation codes and month length helpers
// ----------------------------------------------------------------------------
`default_nettype none

package cdadd_pkg;

   localparam int DEF_YEAR_BITS = 14;
   localparam int OP_W          = 3;
   localparam int MONTH_W       = 4;
   localparam int DAY_W         = 5;
   localparam int MONTHS_W      = 12;
   localparam int COUNT_W       = 16;
   localparam int TOTAL_W       = 13;
   localparam int ACC_W         = 20;
   localparam int MOD_W         = 9;

   localparam int MONTHS_PER_YEAR = 12;
   localparam int LEAP_CYCLE      = 400;

   localparam logic [OP_W-1:0] OP_LOAD       = 3'd0;
   localparam logic [OP_W-1:0] OP_ADD_DAYS   = 3'd1;
   localparam logic [OP_W-1:0] OP_ADD_WEEKS  = 3'd2;
   localparam logic [OP_W-1:0] OP_ADD_MONTHS = 3'd3;
   localparam logic [OP_W-1:0] OP_SUB_DAYS   = 3'd4;
   localparam logic [OP_W-1:0] OP_SUB_MONTHS = 3'd5;

   typedef struct packed {
      logic start;
      logic by_cycle;
   } div_ctl_type;

   function automatic logic is_leap(input logic [MOD_W-1:0] ymod);
      is_leap = (ymod[1:0] == 2'd0) && (ymod != MOD_W'(100)) &&
                (ymod != MOD_W'(200)) && (ymod != MOD_W'(300));
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                  input logic [MONTH_W-1:0] month);
      case (month)
         4'd2: month_len = leap ? DAY_W'(29) : DAY_W'(28);
         4'd4, 4'd6, 4'd9, 4'd11: month_len = DAY_W'(30);
         default: month_len = DAY_W'(31);
      endcase
   endfunction

endpackage

`default_nettype wire

@@ rtl/cdadd_channels.sv @@
// ----------------------------------------------------------------------------
// cdadd channels
// request and response valid/ready interfaces
// ----------------------------------------------------------------------------
`default_nettype none

interface cdadd_req_if #(parameter int YEAR_BITS = cdadd_pkg::DEF_YEAR_BITS);
   logic                             valid;
   logic                             ready;
   logic [cdadd_pkg::OP_W-1:0]       op;
   logic [YEAR_BITS-1:0]             load_year;
   logic [cdadd_pkg::MONTH_W-1:0]    load_month;
   logic [cdadd_pkg::DAY_W-1:0]      load_day;
   logic [cdadd_pkg::MONTHS_W-1:0]   months;
   logic [cdadd_pkg::COUNT_W-1:0]    count;

   modport source(output valid, op, load_year, load_month, load_day, months, count,
                  input ready);
   modport sink(input valid, op, load_year, load_month, load_day, months, count,
                output ready);
endinterface

interface cdadd_rsp_if #(parameter int YEAR_BITS = cdadd_pkg::DEF_YEAR_BITS);
   logic                             valid;
   logic                             ready;
   logic [YEAR_BITS-1:0]             out_year;
   logic [cdadd_pkg::MONTH_W-1:0]    out_month;
   logic [cdadd_pkg::DAY_W-1:0]      out_day;

   modport source(output valid, out_year, out_month, out_day, input ready);
   modport sink(input valid, out_year, out_month, out_day, output ready);
endinterface

`default_nettype wire

@@ rtl/calendar_date_adder_core.sv @@
// ----------------------------------------------------------------------------
// calendar_date_adder_core
// keeps one gregorian date and moves it by days, weeks and months
// ----------------------------------------------------------------------------
// usage:
//   req carries one transaction per command: load a date, add days or weeks,
//   add months then days, subtract days, or subtract months*30 plus days.
//   rsp returns exactly one transaction per command: the date afterwards.
//   req.ready is high only while the core is idle; one command at a time, and
//   ready comes back in the cycle the result turns valid.
//   steps from accept to rsp.valid, by command:
//     load                    year modulo 400 divide, then day clamp
//     add or subtract days    day walk alone
//     add months then days    divide by 12, year modulo 400 divide, day walk
//     unused op codes         straight to the result
//   the day walk crosses one month per cycle; a shared reciprocal-multiply
//   divider by 12 or 400 finds the month carry and the year modulo 400
//   that drives the leap rule.
//   reset (synchronous) sets the date to year 0, month 1, day 1.
//   a finished result sits in an output register; while rsp is stalled the
//   core takes the next command but holds its own result until the slot frees.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_date_adder_core #(
   parameter int YEAR_BITS = cdadd_pkg::DEF_YEAR_BITS
) (
   input  wire logic   clock,
   input  wire logic   reset,
   cdadd_req_if.sink   req_if,
   cdadd_rsp_if.source rsp_if
);

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [YEAR_BITS-1:0]             rsp_year_ff;
   logic [cdadd_pkg::MONTH_W-1:0]    rsp_month_ff;
   logic [cdadd_pkg::DAY_W-1:0]      rsp_day_ff;
   logic                             slot_free;
   logic                             push;
   logic [YEAR_BITS-1:0]             cur_year;
   logic [cdadd_pkg::MONTH_W-1:0]    cur_month;
   logic [cdadd_pkg::DAY_W-1:0]      cur_day;

   cdadd_ctrl #(.YEAR_BITS(YEAR_BITS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .slot_free (slot_free),
      .push      (push),
      .cur_year  (cur_year),
      .cur_month (cur_month),
      .cur_day   (cur_day)
   );

   always_comb begin
      slot_free    = !rsp_valid_ff || rsp_if.ready;
      rsp_valid_in = push ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (push) begin
         rsp_year_ff  <= cur_year;
         rsp_month_ff <= cur_month;
         rsp_day_ff   <= cur_day;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.out_year  = rsp_year_ff;
   assign rsp_if.out_month = rsp_month_ff;
   assign rsp_if.out_day   = rsp_day_ff;

endmodule

`default_nettype wire

@@ rtl/cdadd_cdiv.sv @@
// ----------------------------------------------------------------------------
// cdadd_cdiv
// shared reciprocal-multiply divider by 12 or by 400, in a multiply and a remainder phase
// ----------------------------------------------------------------------------
`default_nettype none

module cdadd_cdiv #(
   parameter int DIV_W = cdadd_pkg::TOTAL_W
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire cdadd_pkg::div_ctl_type            ctl,
   input  wire logic [DIV_W-1:0]                  dividend,
   output logic      [DIV_W-1:0]                  quo,
   output logic      [cdadd_pkg::MOD_W-1:0]       rem,
   output logic                                   done
);

   // x / 12 = (x >> 2) / 3 and x / 400 = (x >> 4) / 25, each by a rounded-up reciprocal
   localparam int PW      = 2 * DIV_W;
   localparam int ODD_12  = cdadd_pkg::MONTHS_PER_YEAR / 4;
   localparam int ODD_400 = cdadd_pkg::LEAP_CYCLE / 16;
   localparam int SHR_12  = DIV_W;
   localparam int SHR_400 = DIV_W + 1;
   localparam longint unsigned RECIP_12  =
      ((64'd1 << SHR_12) + 64'(ODD_12 - 1)) / 64'(ODD_12);
   localparam longint unsigned RECIP_400 =
      ((64'd1 << SHR_400) + 64'(ODD_400 - 1)) / 64'(ODD_400);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_MUL  = 2'd1;
   localparam logic [1:0] PH_REM  = 2'd2;

   logic [1:0]                    phase_ff, phase_in;
   logic [DIV_W-1:0]              dvd_ff, dvd_in;
   logic [DIV_W-1:0]              opnd_ff, opnd_in;
   logic [PW-1:0]                 prod_ff, prod_in;
   logic [DIV_W-1:0]              quo_ff, quo_in;
   logic [cdadd_pkg::MOD_W-1:0]   rem_ff, rem_in;
   logic                          done_ff, done_in;
   logic                          sel_ff, sel_in;
   logic [DIV_W-1:0]              recip;
   logic [DIV_W-1:0]              q_est;
   logic [DIV_W-1:0]              q_times_d;

   always_comb begin
      recip     = sel_ff ? DIV_W'(RECIP_400) : DIV_W'(RECIP_12);
      q_est     = sel_ff ? DIV_W'(prod_ff >> SHR_400) : DIV_W'(prod_ff >> SHR_12);
      // quotient times 400 or 12 as shifted sums
      q_times_d = sel_ff ? (q_est << 8) + (q_est << 7) + (q_est << 4)
                         : (q_est << 3) + (q_est << 2);
      phase_in  = phase_ff;
      dvd_in    = dvd_ff;
      opnd_in   = opnd_ff;
      prod_in   = prod_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      sel_in    = sel_ff;
      done_in   = 1'b0;
      if (ctl.start) begin
         dvd_in   = dividend;
         opnd_in  = ctl.by_cycle ? (dividend >> 4) : (dividend >> 2);
         sel_in   = ctl.by_cycle;
         phase_in = PH_MUL;
      end else begin
         case (phase_ff)
            PH_IDLE: begin
               phase_in = PH_IDLE;
            end
            PH_MUL: begin
               prod_in  = PW'(opnd_ff) * PW'(recip);
               phase_in = PH_REM;
            end
            PH_REM: begin
               quo_in   = q_est;
               rem_in   = cdadd_pkg::MOD_W'(dvd_ff - q_times_d);
               done_in  = 1'b1;
               phase_in = PH_IDLE;
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      dvd_ff  <= dvd_in;
      opnd_ff <= opnd_in;
      prod_ff <= prod_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      sel_ff  <= sel_in;
   end

   assign quo  = quo_ff;
   assign rem  = rem_ff;
   assign done = done_ff;

endmodule

`default_nettype wire

@@ rtl/cdadd_ctrl.sv @@
// ----------------------------------------------------------------------------
// cdadd_ctrl
// date registers, sequencer and the month-at-a-time day walk
// ----------------------------------------------------------------------------
`default_nettype none

`include "calendar_date_adder_core_assert.svh"

module cdadd_ctrl #(
   parameter int YEAR_BITS = cdadd_pkg::DEF_YEAR_BITS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   cdadd_req_if.sink                           req,
   input  wire logic                           slot_free,
   output logic                                push,
   output logic [YEAR_BITS-1:0]                cur_year,
   output logic [cdadd_pkg::MONTH_W-1:0]       cur_month,
   output logic [cdadd_pkg::DAY_W-1:0]         cur_day
);

   localparam int DIV_W = (YEAR_BITS > cdadd_pkg::TOTAL_W) ? YEAR_BITS : cdadd_pkg::TOTAL_W;
   localparam int MW    = cdadd_pkg::MOD_W;
   localparam int AW    = cdadd_pkg::ACC_W;
   localparam int HW    = cdadd_pkg::MONTH_W;
   localparam int DW    = cdadd_pkg::DAY_W;
   localparam longint unsigned YEAR_TOP = (64'd1 << YEAR_BITS) - 64'd1;
   localparam logic [MW-1:0] TOP_MOD  = MW'(YEAR_TOP % 64'd400);
   localparam logic [MW-1:0] MOD_LAST = MW'(cdadd_pkg::LEAP_CYCLE - 1);

   localparam logic [2:0] ST_IDLE       = 3'd0;
   localparam logic [2:0] ST_M3_DIV     = 3'd1;
   localparam logic [2:0] ST_YMOD_START = 3'd2;
   localparam logic [2:0] ST_YMOD_WAIT  = 3'd3;
   localparam logic [2:0] ST_LD_CLAMP   = 3'd4;
   localparam logic [2:0] ST_ADD_WALK   = 3'd5;
   localparam logic [2:0] ST_SUB_WALK   = 3'd6;
   localparam logic [2:0] ST_DONE       = 3'd7;

   logic [2:0]                       state_ff, state_in;
   logic [YEAR_BITS-1:0]             year_ff, year_in;
   logic [HW-1:0]                    month_ff, month_in;
   logic [DW-1:0]                    day_ff, day_in;
   logic [MW-1:0]                    ymod_ff, ymod_in;
   logic [AW-1:0]                    acc_ff, acc_in;
   logic [cdadd_pkg::OP_W-1:0]       op_ff, op_in;
   logic [cdadd_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic [DW-1:0]                    ld_day_ff, ld_day_in;

   cdadd_pkg::div_ctl_type           div_ctl;
   logic [DIV_W-1:0]                 div_dividend;
   logic [DIV_W-1:0]                 div_quo;
   logic [MW-1:0]                    div_rem;
   logic                             div_done;

   logic [DW-1:0]                    len_cur;
   logic [DW-1:0]                    len_prev;
   logic [AW-1:0]                    cnt_ext, mon_ext, day_ext;
   logic [cdadd_pkg::TOTAL_W-1:0]    total;
   logic [HW-1:0]                    ld_month;
   logic [YEAR_BITS-1:0]             year_inc, year_dec;
   logic [MW-1:0]                    ymod_inc, ymod_dec;
   logic                             acc_nonpos;

   cdadd_cdiv #(.DIV_W(DIV_W)) u_cdiv (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (div_dividend),
      .quo      (div_quo),
      .rem      (div_rem),
      .done     (div_done)
   );

   always_comb begin
      len_cur    = cdadd_pkg::month_len(cdadd_pkg::is_leap(ymod_ff), month_ff);
      len_prev   = (month_ff <= HW'(1)) ? DW'(31)
                 : cdadd_pkg::month_len(cdadd_pkg::is_leap(ymod_ff), month_ff - HW'(1));
      cnt_ext    = AW'(req.count);
      mon_ext    = AW'(req.months);
      day_ext    = AW'(day_ff);
      total      = cdadd_pkg::TOTAL_W'(month_ff - HW'(1)) + cdadd_pkg::TOTAL_W'(req.months);
      ld_month   = (req.load_month == '0) ? HW'(1)
                 : (req.load_month > HW'(12)) ? HW'(12) : req.load_month;
      year_inc   = year_ff + YEAR_BITS'(1);
      year_dec   = year_ff - YEAR_BITS'(1);
      ymod_inc   = (year_ff == '1 || ymod_ff == MOD_LAST) ? '0 : ymod_ff + MW'(1);
      ymod_dec   = (year_ff == '0) ? TOP_MOD
                 : (ymod_ff == '0) ? MOD_LAST : ymod_ff - MW'(1);
      acc_nonpos = acc_ff[AW-1] || (acc_ff == '0);

      state_in   = state_ff;
      year_in    = year_ff;
      month_in   = month_ff;
      day_in     = day_ff;
      ymod_in    = ymod_ff;
      acc_in     = acc_ff;
      op_in      = op_ff;
      count_in   = count_ff;
      ld_day_in  = ld_day_ff;
      div_ctl    = '0;
      div_dividend = (state_ff == ST_IDLE) ? DIV_W'(total) : DIV_W'(year_ff);
      push       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               op_in    = req.op;
               count_in = req.count;
               case (req.op)
                  cdadd_pkg::OP_LOAD: begin
                     year_in   = req.load_year;
                     month_in  = ld_month;
                     ld_day_in = req.load_day;
                     state_in  = ST_YMOD_START;
                  end
                  cdadd_pkg::OP_ADD_DAYS: begin
                     acc_in   = day_ext + cnt_ext;
                     state_in = ST_ADD_WALK;
                  end
                  cdadd_pkg::OP_ADD_WEEKS: begin
                     acc_in   = day_ext + (cnt_ext << 3) - cnt_ext;
                     state_in = ST_ADD_WALK;
                  end
                  cdadd_pkg::OP_ADD_MONTHS: begin
                     div_ctl.start    = 1'b1;
                     div_ctl.by_cycle = 1'b0;
                     state_in         = ST_M3_DIV;
                  end
                  cdadd_pkg::OP_SUB_DAYS: begin
                     acc_in   = day_ext - cnt_ext;
                     state_in = ST_SUB_WALK;
                  end
                  cdadd_pkg::OP_SUB_MONTHS: begin
                     acc_in   = day_ext - ((mon_ext << 5) - (mon_ext << 1)) - cnt_ext;
                     state_in = ST_SUB_WALK;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_M3_DIV: begin
            if (div_done) begin
               year_in  = year_ff + YEAR_BITS'(div_quo);
               month_in = HW'(div_rem) + HW'(1);
               acc_in   = day_ext + AW'(count_ff);
               state_in = ST_YMOD_START;
            end
         end
         ST_YMOD_START: begin
            div_ctl.start    = 1'b1;
            div_ctl.by_cycle = 1'b1;
            state_in         = ST_YMOD_WAIT;
         end
         ST_YMOD_WAIT: begin
            if (div_done) begin
               ymod_in  = div_rem;
               state_in = (op_ff == cdadd_pkg::OP_LOAD) ? ST_LD_CLAMP : ST_ADD_WALK;
            end
         end
         ST_LD_CLAMP: begin
            day_in   = (ld_day_ff == '0) ? DW'(1)
                     : (ld_day_ff > len_cur) ? len_cur : ld_day_ff;
            state_in = ST_DONE;
         end
         ST_ADD_WALK: begin
            if (acc_ff > AW'(len_cur)) begin
               acc_in = acc_ff - AW'(len_cur);
               if (month_ff >= HW'(12)) begin
                  month_in = HW'(1);
                  year_in  = year_inc;
                  ymod_in  = ymod_inc;
               end else begin
                  month_in = month_ff + HW'(1);
               end
            end else begin
               day_in   = DW'(acc_ff);
               state_in = ST_DONE;
            end
         end
         ST_SUB_WALK: begin
            if (acc_nonpos) begin
               acc_in = acc_ff + AW'(len_prev);
               if (month_ff <= HW'(1)) begin
                  month_in = HW'(12);
                  year_in  = year_dec;
                  ymod_in  = ymod_dec;
               end else begin
                  month_in = month_ff - HW'(1);
               end
            end else begin
               day_in   = DW'(acc_ff);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               push     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         year_ff  <= '0;
         month_ff <= HW'(1);
         day_ff   <= DW'(1);
         ymod_ff  <= '0;
      end else begin
         state_ff <= state_in;
         year_ff  <= year_in;
         month_ff <= month_in;
         day_ff   <= day_in;
         ymod_ff  <= ymod_in;
      end
      acc_ff    <= acc_in;
      op_ff     <= op_in;
      count_ff  <= count_in;
      ld_day_ff <= ld_day_in;
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign cur_year  = year_ff;
   assign cur_month = month_ff;
   assign cur_day   = day_ff;

   `CDADD_ASSERT_ALWAYS(a_month_range, (month_ff >= HW'(1)) && (month_ff <= HW'(12)))
   `CDADD_ASSERT_ALWAYS(a_day_nonzero, day_ff != '0)
   `CDADD_ASSERT_ALWAYS(a_ymod_range, ymod_ff <= MOD_LAST)
   `CDADD_ASSERT_ALWAYS(a_div_done_waiting, !div_done || state_ff == ST_M3_DIV || state_ff == ST_YMOD_WAIT)
   `CDADD_ASSERT_NEXT(a_accept_leaves_idle, req.valid && req.ready, state_ff != ST_IDLE)

endmodule

`default_nettype wire
